// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define TLBF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TLBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tlbf_pkg.sv -----
// package: constants, command codes and control structs of the bloom filter
package tlbf_pkg;

   localparam int HASH_COUNT_DEF = 4;
   localparam int RESULT_CAP_DEF = 256;
   localparam int ARRAY_BITS_DEF = 65536;

   localparam int CMD_W     = 3;
   localparam int KEY_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 14;
   localparam int FOUND_W   = 9;
   localparam int HIDX_W    = 5;

   localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CHK_UPD = 3'd2;
   localparam logic [CMD_W-1:0] CMD_UPD_SEC = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_PRIMARY_BYTES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SECONDARY_BYTES = 2'd1;
   localparam logic [CSR_W-1:0]     BYTES_RESET         = 14'd8192;

   localparam logic [31:0] SEC_SEED_OFS = 32'hA5A5A5A5;
   localparam logic [63:0] SECRET_Q1    = 64'h1CAD21F72C81017C;
   localparam logic [63:0] SECRET_Q2    = 64'hDB979083E96DD4DE;
   localparam logic [63:0] SECRET_QX    = SECRET_Q1 ^ SECRET_Q2;
   localparam logic [63:0] RRMX_MUL     = 64'h9FB21C651E98DF25;
   localparam logic [63:0] KEY_LEN      = 64'd4;

   // dividend bits shifted in per divide step, and steps for a 64-bit dividend
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = 64 / DIV_BITS;

   localparam logic [1:0] MUL_LAST = 2'd2;

   typedef struct packed {
      logic              load;
      logic              clear;
      logic              pre;
      logic              mul;
      logic              mid;
      logic              fin;
      logic              div;
      logic              rd;
      logic              upd;
      logic              finish;
      logic [1:0]        part;
      logic              sec;
      logic              set_mode;
      logic [HIDX_W-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic miss;
   } dp_status_type;

endpackage

// ----- rtl/two_level_bloom_filter.sv -----
// top level of the two-level bloom filter
//
// command channel: a command transfers at a rising edge with start high and busy
// low; req_cmd, req_key and req_list_end are sampled at that edge
// result channel: one result per command, shown for one cycle with rsp_valid
// high; the receiver cannot stall, so the result transfers at the end of it
// config channel: csr_ready is always high; index 0 sets the primary array size
// in bytes, index 1 the secondary; the user must make writes only while idle,
// which the block itself leaves unchecked
// hashing: each hash goes through the one shared hash unit (seed mix, two
// 64-bit products as three 32x32 steps each, a 64-bit remainder at 4 bits per
// cycle, row read, row write); check and update on a primary hit runs a second
// pass; unknown command codes skip the hashing and return a result
// flow: busy drops in the strobe cycle, so the next command can transfer
// at the edge that ends it; one command in flight at a time
// reset: both bit memories are swept to zero one byte row per cycle,
// with busy high; config writes are still taken
module two_level_bloom_filter
   import tlbf_pkg::*;
#(
   parameter int HASH_COUNT = HASH_COUNT_DEF,
   parameter int RESULT_CAP = RESULT_CAP_DEF,
   parameter int ARRAY_BITS = ARRAY_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [KEY_W-1:0]     req_key,
   input  logic                 req_list_end,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic                 rsp_accepted,
   output logic [FOUND_W-1:0]   rsp_found_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // command and status between controller and datapath
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // size registers accept a transfer every cycle
   assign csr_ready = 1'b1;

   tlbf_ctrl #(
      .HASH_COUNT(HASH_COUNT)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .status  (dp_status),
      .dp_cmd  (dp_cmd),
      .busy    (busy)
   );

   tlbf_datapath #(
      .RESULT_CAP(RESULT_CAP),
      .ARRAY_BITS(ARRAY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .status          (dp_status),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_list_end    (req_list_end),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_accepted    (rsp_accepted),
      .rsp_found_count (rsp_found_count)
   );

endmodule

// ----- rtl/tlbf_ctrl.sv -----
// controller state machine: clearing pass, hash sequencing and command flow
`include "assert_macros.svh"

module tlbf_ctrl
   import tlbf_pkg::*;
#(
   parameter int HASH_COUNT = HASH_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CMD_W-1:0] req_cmd,
   input  dp_status_type    status,
   output dp_cmd_type       dp_cmd,
   output logic             busy
);

   typedef enum logic [11:0] {
      ST_CLEAR = 12'b000000000001,
      ST_IDLE  = 12'b000000000010,
      ST_PRE   = 12'b000000000100,
      ST_MUL1  = 12'b000000001000,
      ST_MID   = 12'b000000010000,
      ST_MUL2  = 12'b000000100000,
      ST_FIN   = 12'b000001000000,
      ST_DIV   = 12'b000010000000,
      ST_RD    = 12'b000100000000,
      ST_UPD   = 12'b001000000000,
      ST_EVAL  = 12'b010000000000,
      ST_DONE  = 12'b100000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic              sec_ff, sec_in;
   logic              set_ff, set_in;
   logic [HIDX_W-1:0] idx_ff, idx_in;
   logic [3:0]        cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cmd_ff   <= CMD_ADD;
         sec_ff   <= 1'b0;
         set_ff   <= 1'b0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         sec_ff   <= sec_in;
         set_ff   <= set_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      sec_in   = sec_ff;
      set_in   = set_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      dp_cmd   = '0;
      case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clear = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               dp_cmd.load = 1'b1;
               cmd_in      = req_cmd;
               idx_in      = '0;
               state_in    = ST_PRE;
               case (req_cmd)
                  CMD_ADD: begin
                     sec_in = 1'b0;
                     set_in = 1'b1;
                  end
                  CMD_CHECK, CMD_CHK_UPD: begin
                     sec_in = 1'b0;
                     set_in = 1'b0;
                  end
                  CMD_UPD_SEC: begin
                     sec_in = 1'b1;
                     set_in = 1'b1;
                  end
                  CMD_QUERY: begin
                     sec_in = 1'b1;
                     set_in = 1'b0;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_PRE: begin
            dp_cmd.pre = 1'b1;
            cnt_in     = '0;
            state_in   = ST_MUL1;
         end
         ST_MUL1, ST_MUL2: begin
            dp_cmd.mul  = 1'b1;
            dp_cmd.part = cnt_ff[1:0];
            if (cnt_ff[1:0] == MUL_LAST) begin
               cnt_in   = '0;
               state_in = (state_ff == ST_MUL1) ? ST_MID : ST_FIN;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_MID: begin
            dp_cmd.mid = 1'b1;
            state_in   = ST_MUL2;
         end
         ST_FIN: begin
            dp_cmd.fin = 1'b1;
            cnt_in     = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            dp_cmd.div = 1'b1;
            cnt_in     = cnt_ff + 4'd1;
            if (cnt_ff == 4'(DIV_STEPS - 1)) state_in = ST_RD;
         end
         ST_RD: begin
            dp_cmd.rd = 1'b1;
            state_in  = ST_UPD;
         end
         ST_UPD: begin
            dp_cmd.upd = 1'b1;
            if (idx_ff == HIDX_W'(HASH_COUNT - 1)) begin
               state_in = ST_EVAL;
            end else begin
               idx_in   = idx_ff + HIDX_W'(1);
               state_in = ST_PRE;
            end
         end
         ST_EVAL: begin
            // check and update: a primary hit runs a second pass setting secondary
            if (cmd_ff == CMD_CHK_UPD && !sec_ff && !status.miss) begin
               sec_in   = 1'b1;
               set_in   = 1'b1;
               idx_in   = '0;
               state_in = ST_PRE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            dp_cmd.finish = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
      dp_cmd.sec      = sec_ff;
      dp_cmd.set_mode = set_ff;
      dp_cmd.idx      = idx_ff;
   end

   assign busy = (state_ff != ST_IDLE);

   `TLBF_ASSERT_NEXT(a_done_to_idle, clock, reset, state_ff == ST_DONE, state_ff == ST_IDLE, "done must return to idle")
   `TLBF_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted command must make the block busy")
   `TLBF_ASSERT_NOW(a_idx_range, clock, reset, 1'b1, idx_ff < HIDX_W'(HASH_COUNT), "hash index out of range")

endmodule

// ----- rtl/tlbf_datapath.sv -----
// datapath: size registers, hash unit, divider, bit memories and result register
`include "assert_macros.svh"

module tlbf_datapath
   import tlbf_pkg::*;
#(
   parameter int RESULT_CAP = RESULT_CAP_DEF,
   parameter int ARRAY_BITS = ARRAY_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           dp_cmd,
   output dp_status_type        status,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [KEY_W-1:0]     req_key,
   input  logic                 req_list_end,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic                 rsp_accepted,
   output logic [FOUND_W-1:0]   rsp_found_count
);

   localparam int ARRAY_BYTES = ARRAY_BITS / 8;
   localparam int ROWS        = ARRAY_BYTES;
   localparam int BW          = $clog2(ARRAY_BYTES + 1);
   localparam int MW          = BW + 3;
   localparam int IW          = $clog2(ARRAY_BITS);
   localparam int AW          = (IW > 3) ? IW - 3 : 1;
   localparam int CW          = $clog2(RESULT_CAP + 1);

   function automatic logic [BW-1:0] clamp_bytes(input logic [CSR_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w == 32'd0) w = 32'd1;
      if (w > 32'(ARRAY_BYTES)) w = 32'(ARRAY_BYTES);
      return BW'(w);
   endfunction

   logic [BW-1:0]    pbytes_ff, sbytes_ff;
   logic [CMD_W-1:0] cmd_ff;
   logic [KEY_W-1:0] key_ff;
   logic             last_ff;
   logic [63:0]      mul_a_ff, acc_ff, q_ff;
   logic [MW-1:0]    rem_ff;
   logic [7:0]       pri_rd_ff, sec_rd_ff;
   logic             miss_ff;
   logic [AW-1:0]    clr_addr_ff;
   logic [CW-1:0]    cnt_ff;
   logic             rsp_valid_ff, rsp_hit_ff, rsp_acc_ff;
   logic [FOUND_W-1:0] rsp_found_ff;

   logic [7:0] pri_mem [ROWS];
   logic [7:0] sec_mem [ROWS];

   // size registers, clamped on write
   always_ff @(posedge clock) begin
      if (reset) begin
         pbytes_ff <= clamp_bytes(BYTES_RESET);
         sbytes_ff <= clamp_bytes(BYTES_RESET);
      end else if (csr_valid) begin
         if (csr_index == REG_PRIMARY_BYTES)   pbytes_ff <= clamp_bytes(csr_wdata);
         if (csr_index == REG_SECONDARY_BYTES) sbytes_ff <= clamp_bytes(csr_wdata);
      end
   end

   // seed mixing for a four-byte key
   logic [31:0] seed32, seed_sw;
   logic [63:0] h0, h1;
   always_comb begin
      seed32  = dp_cmd.sec ? (SEC_SEED_OFS + 32'(dp_cmd.idx)) : 32'(dp_cmd.idx);
      seed_sw = {seed32[7:0], seed32[15:8], seed32[23:16], seed32[31:24]};
      h0      = {key_ff, key_ff} ^ (SECRET_QX - {seed_sw, seed32});
      h1      = h0 ^ {h0[14:0], h0[63:15]} ^ {h0[39:0], h0[63:40]};
   end

   // 64x64 low product from three 32x32 partial products
   logic [31:0] mx, my;
   logic [63:0] prod, mid_h, fin_h;
   always_comb begin
      case (dp_cmd.part)
         2'd0:    begin mx = mul_a_ff[31:0];  my = RRMX_MUL[31:0];  end
         2'd1:    begin mx = mul_a_ff[63:32]; my = RRMX_MUL[31:0];  end
         default: begin mx = mul_a_ff[31:0];  my = RRMX_MUL[63:32]; end
      endcase
      prod  = 64'(mx) * 64'(my);
      mid_h = acc_ff ^ ((acc_ff >> 35) + KEY_LEN);
      fin_h = acc_ff ^ (acc_ff >> 28);
   end

   // restoring remainder, DIV_BITS dividend bits per divide step
   logic [MW-1:0] modulus;
   logic [MW:0]   r_t;
   logic [63:0]   q_t;
   always_comb begin
      modulus = dp_cmd.sec ? {sbytes_ff, 3'b000} : {pbytes_ff, 3'b000};
      r_t     = {1'b0, rem_ff};
      q_t     = q_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         r_t = {r_t[MW-1:0], q_t[63]};
         q_t = {q_t[62:0], 1'b0};
         if (r_t >= {1'b0, modulus}) r_t = r_t - {1'b0, modulus};
      end
   end

   logic [IW-1:0] bit_idx;
   logic [AW-1:0] row_addr;
   logic [7:0]    row_data, bit_mask;
   assign bit_idx  = rem_ff[IW-1:0];
   assign row_addr = AW'(bit_idx >> 3);
   assign bit_mask = 8'(1) << bit_idx[2:0];
   assign row_data = dp_cmd.sec ? sec_rd_ff : pri_rd_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff  <= req_cmd;
         key_ff  <= req_key;
         last_ff <= req_list_end;
      end
      if (dp_cmd.pre) mul_a_ff <= h1;
      if (dp_cmd.mid) mul_a_ff <= mid_h;
      if (dp_cmd.mul) begin
         if (dp_cmd.part == 2'd0) acc_ff <= prod;
         else                     acc_ff <= acc_ff + {prod[31:0], 32'd0};
      end
      if (dp_cmd.fin) begin
         q_ff   <= fin_h;
         rem_ff <= '0;
      end
      if (dp_cmd.div) begin
         q_ff   <= q_t;
         rem_ff <= r_t[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.clear) pri_mem[clr_addr_ff] <= 8'd0;
      else if (dp_cmd.upd && dp_cmd.set_mode && !dp_cmd.sec)
         pri_mem[row_addr] <= pri_rd_ff | bit_mask;
      if (dp_cmd.rd) pri_rd_ff <= pri_mem[row_addr];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.clear) sec_mem[clr_addr_ff] <= 8'd0;
      else if (dp_cmd.upd && dp_cmd.set_mode && dp_cmd.sec)
         sec_mem[row_addr] <= sec_rd_ff | bit_mask;
      if (dp_cmd.rd) sec_rd_ff <= sec_mem[row_addr];
   end

   // control state: clear sweep, miss flag, list count, result strobe
   logic          hit_w, acc_w;
   logic [CW-1:0] cnt_new;
   logic [31:0]   cnt_wide;
   always_comb begin
      hit_w    = !miss_ff && (cmd_ff == CMD_CHECK || cmd_ff == CMD_CHK_UPD ||
                              cmd_ff == CMD_QUERY);
      acc_w    = hit_w && cmd_ff == CMD_QUERY && cnt_ff < CW'(RESULT_CAP);
      cnt_new  = acc_w ? cnt_ff + CW'(1) : cnt_ff;
      cnt_wide = 32'(cnt_new);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         miss_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dp_cmd.finish;
         if (dp_cmd.clear) clr_addr_ff <= clr_addr_ff + AW'(1);
         if (dp_cmd.load) miss_ff <= 1'b0;
         else if (dp_cmd.upd && !dp_cmd.set_mode && (row_data & bit_mask) == 8'd0)
            miss_ff <= 1'b1;
         if (dp_cmd.finish)
            cnt_ff <= (cmd_ff == CMD_QUERY && last_ff) ? '0 : cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.finish) begin
         rsp_hit_ff   <= hit_w;
         rsp_acc_ff   <= acc_w;
         rsp_found_ff <= cnt_wide[FOUND_W-1:0];
      end
   end

   assign status          = '{clr_last: (clr_addr_ff == AW'(ROWS - 1)), miss: miss_ff};
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_found_count = rsp_found_ff;

   `TLBF_ASSERT_NOW(a_acc_hit, clock, reset, rsp_valid && rsp_accepted, rsp_hit, "accepted without hit")
   `TLBF_ASSERT_NOW(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CW'(RESULT_CAP), "list count above cap")
   `TLBF_ASSERT_NEXT(a_rem_range, clock, reset, dp_cmd.div, rem_ff < modulus, "remainder not below modulus")

endmodule
